FILE: design/bfsa_pkg.sv
// Shared types and constants of the best-fit scratch allocator.
package bfsa_pkg;

    localparam int ACT_W    = 2;
    localparam int ID_W     = 8;
    localparam int CNT_W    = 32;
    localparam int ELEM_W   = 5;
    localparam int STATUS_W = 3;
    localparam int OUT_W    = 32;
    localparam int VEC_ALIGN_BITS = 4;

    typedef enum logic [ACT_W-1:0] {
        ACT_ALLOC    = 2'd0,
        ACT_FREE     = 2'd1,
        ACT_FINALIZE = 2'd2,
        ACT_NONE     = 2'd3
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_FINALIZED = 3'd1,
        ST_DOUBLE    = 3'd2,
        ST_NOT_LIVE  = 3'd3,
        ST_OVERFLOW  = 3'd4,
        ST_VEC_MIS   = 3'd5,
        ST_ELEM_MIS  = 3'd6,
        ST_FULL      = 3'd7
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_ASCAN,
        S_APLACE,
        S_FREE_CHK,
        S_FSCAN,
        S_FMERGE,
        S_SHIFT_DN,
        S_SHIFT_UP,
        S_FIN_SCAN,
        S_FIN_CHK,
        S_FIN_MOD,
        S_DONE
    } state_t;

endpackage

FILE: design/best_fit_scratch_allocator_unit.sv
// Top level of the best-fit scratch allocator with a sorted, coalescing free table.
//
//  channel | valid     | stall     | words carried
//  --------+-----------+-----------+-------------------------------------------------
//  request | req_valid | req_stall | action, value_id, element_count, element_size
//  result  | rsp_valid | rsp_stall | status, offset, reserved_bytes, pool_bytes
//
// One word is worked on at a time; the free table sits in a one-port-read memory,
// so an allocate scans the whole free table and squeezes out a range that it empties,
// and a free scans the table and then shifts its entries down or up.
// Finalize walks every value id; for each allocated one it checks the offset's vector
// alignment and, for a nonzero element size, divides the offset in the remainder unit.
// Reset clears flags, counters and cursor at once; no clearing pass is needed.
// A held result does not block the next request word; it waits only at its end.
module best_fit_scratch_allocator_unit
    import bfsa_pkg::*;
#(
    parameter int FREE_SLOTS  = 16,
    parameter int VALUE_COUNT = 256,
    parameter int ADDR_BITS   = 32,
    parameter int ALIGNMENT   = 256
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  logic [ACT_W-1:0]    action,
    input  logic [ID_W-1:0]     value_id,
    input  logic [CNT_W-1:0]    element_count,
    input  logic [ELEM_W-1:0]   element_size,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output logic [STATUS_W-1:0] status,
    output logic [OUT_W-1:0]    offset,
    output logic [OUT_W-1:0]    reserved_bytes,
    output logic [OUT_W-1:0]    pool_bytes
);

    localparam int AW  = ADDR_BITS;
    localparam int FSW = (FREE_SLOTS > 1) ? $clog2(FREE_SLOTS) : 1;
    localparam int FCW = $clog2(FREE_SLOTS + 1);
    localparam int VW  = (VALUE_COUNT > 1) ? $clog2(VALUE_COUNT) : 1;
    localparam int VCW = $clog2(VALUE_COUNT + 1);
    localparam int PRW = CNT_W + ELEM_W;
    localparam int EW  = ((AW > PRW) ? AW : PRW) + 1;
    localparam int FTW = 2 * AW;
    localparam int PMW = 2 * AW + ELEM_W;

    localparam logic [EW-1:0] BYTES_LIM =
        ((EW'(1) << AW) - EW'(1)) - EW'(ALIGNMENT - 1);
    localparam logic [EW-1:0] ALIGN_M1_E = EW'(ALIGNMENT - 1);
    localparam logic [AW-1:0] AMAX      = {AW{1'b1}};
    localparam logic [AW-1:0] ALIGN_M1  = AW'(ALIGNMENT - 1);
    localparam logic [AW-1:0] CUR_LIM   = AMAX - ALIGN_M1;

    // Value id folded into the table range, one restoring step per id bit.
    function automatic logic [VW-1:0] id_fold(input logic [ID_W-1:0] v);
        logic [13:0] r;
        r = '0;
        for (int k = ID_W - 1; k >= 0; k--)
        begin
            r = {r[12:0], v[k]};
            if (r >= 14'(VALUE_COUNT))
            begin
                r = r - 14'(VALUE_COUNT);
            end
        end
        return VW'(r);
    endfunction

    state_t state_reg, state_next;

    logic [ACT_W-1:0]  act_reg, act_next;
    logic [VW-1:0]     id_reg, id_next;
    logic [ELEM_W-1:0] esize_reg, esize_next;
    logic [PRW-1:0]    bytes_reg, bytes_next;
    logic [AW-1:0]     resv_reg, resv_next;
    logic [AW-1:0]     off_reg, off_next;
    logic [AW-1:0]     cursor_reg, cursor_next;
    logic [FCW-1:0]    fcount_reg, fcount_next;
    logic              finalized_reg, finalized_next;
    logic [VALUE_COUNT-1:0] alloc_reg, alloc_next;
    logic [VALUE_COUNT-1:0] live_reg, live_next;

    logic [FCW-1:0]    idx_reg, idx_next;
    logic              pend_reg, pend_next;
    logic [FSW-1:0]    pidx_reg, pidx_next;

    logic              bfound_reg, bfound_next;
    logic [FSW-1:0]    bidx_reg, bidx_next;
    logic [AW-1:0]     bsize_reg, bsize_next;
    logic [AW-1:0]     boff_reg, boff_next;

    logic [FCW-1:0]    pos_reg, pos_next;
    logic              stop_reg, stop_next;
    logic [AW-1:0]     poff_reg, poff_next;
    logic [AW-1:0]     psize_reg, psize_next;
    logic [AW-1:0]     noff_reg, noff_next;
    logic [AW-1:0]     nsize_reg, nsize_next;

    logic [VCW-1:0]    fin_reg, fin_next;

    logic [STATUS_W-1:0] rst_st_reg, rst_st_next;
    logic [AW-1:0]     res_off_reg, res_off_next;
    logic [AW-1:0]     res_resv_reg, res_resv_next;

    logic                rsp_valid_reg, rsp_valid_next;
    logic [STATUS_W-1:0] rsp_st_reg, rsp_st_next;
    logic [OUT_W-1:0]    rsp_off_reg, rsp_off_next;
    logic [OUT_W-1:0]    rsp_resv_reg, rsp_resv_next;
    logic [OUT_W-1:0]    rsp_pool_reg, rsp_pool_next;

    // Free table and placement memories.
    logic [FTW-1:0] ftab [FREE_SLOTS];
    logic           fr_en, fw_en;
    logic [FSW-1:0] fr_addr, fw_addr;
    logic [FTW-1:0] fw_data, fr_data;

    logic [PMW-1:0] pmem [VALUE_COUNT];
    logic           pr_en, pw_en;
    logic [VW-1:0]  pr_addr;
    logic [PMW-1:0] pw_data, pr_data;

    logic              mod_start, mod_done;
    logic [ELEM_W-1:0] mod_rem;

    // Decoded helpers.
    logic [EW-1:0]     bytes_e;
    logic              bytes_ovf;
    logic [AW-1:0]     cur_al;
    logic [AW-1:0]     base;
    logic              place_ovf;
    logic [AW-1:0]     new_size;
    logic              scan_end;
    logic              scan_rd;
    logic [AW-1:0]     fr_off, fr_size;
    logic [AW-1:0]     pr_off, pr_resv;
    logic [ELEM_W-1:0] pr_es;
    logic              mp, mn, tab_full;
    logic [VW-1:0]     fin_id;
    logic              out_free;

    assign bytes_e   = EW'(bytes_reg);
    assign bytes_ovf = bytes_e > BYTES_LIM;
    assign cur_al    = (cursor_reg + ALIGN_M1) & ~ALIGN_M1;
    assign base      = bfound_reg ? boff_reg : cur_al;
    assign place_ovf = (!bfound_reg && (cursor_reg > CUR_LIM)) || (base > (AMAX - resv_reg));
    assign new_size  = bsize_reg - resv_reg;
    assign scan_rd   = idx_reg != fcount_reg;
    assign scan_end  = !scan_rd && !pend_reg;
    assign fr_off    = fr_data[FTW-1:AW];
    assign fr_size   = fr_data[AW-1:0];
    assign pr_off    = pr_data[PMW-1:AW+ELEM_W];
    assign pr_resv   = pr_data[AW+ELEM_W-1:ELEM_W];
    assign pr_es     = pr_data[ELEM_W-1:0];
    assign mp        = (pos_reg != '0) && ((poff_reg + psize_reg) == off_reg);
    assign mn        = stop_reg && ((off_reg + resv_reg) == noff_reg);
    assign tab_full  = !mp && !mn && (fcount_reg >= FCW'(FREE_SLOTS));
    assign fin_id    = fin_reg[VW-1:0];
    assign out_free  = !rsp_valid_reg || !rsp_stall;

    assign req_stall = state_reg != S_IDLE;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (act_reg == ACT_NONE || finalized_reg)
                begin
                    state_next = S_DONE;
                end
                else if (act_reg == ACT_ALLOC)
                begin
                    state_next = (alloc_reg[id_reg] || bytes_ovf) ? S_DONE : S_ASCAN;
                end
                else if (act_reg == ACT_FREE)
                begin
                    state_next = live_reg[id_reg] ? S_FREE_CHK : S_DONE;
                end
                else
                begin
                    state_next = S_FIN_SCAN;
                end
            end
            S_ASCAN:
            begin
                if (scan_end)
                begin
                    state_next = S_APLACE;
                end
            end
            S_APLACE:
            begin
                if (!place_ovf && bfound_reg && new_size == '0)
                begin
                    state_next = S_SHIFT_DN;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_FREE_CHK:
            begin
                state_next = (pr_resv == '0) ? S_DONE : S_FSCAN;
            end
            S_FSCAN:
            begin
                if (scan_end)
                begin
                    state_next = S_FMERGE;
                end
            end
            S_FMERGE:
            begin
                if (tab_full || (mp != mn))
                begin
                    state_next = S_DONE;
                end
                else if (mp && mn)
                begin
                    state_next = S_SHIFT_DN;
                end
                else
                begin
                    state_next = S_SHIFT_UP;
                end
            end
            S_SHIFT_DN:
            begin
                if (scan_end)
                begin
                    state_next = S_DONE;
                end
            end
            S_SHIFT_UP:
            begin
                if (idx_reg == pos_reg && !pend_reg)
                begin
                    state_next = S_DONE;
                end
            end
            S_FIN_SCAN:
            begin
                if (fin_reg == VCW'(VALUE_COUNT))
                begin
                    state_next = S_DONE;
                end
                else if (alloc_reg[fin_id])
                begin
                    state_next = S_FIN_CHK;
                end
            end
            S_FIN_CHK:
            begin
                if (pr_off[VEC_ALIGN_BITS-1:0] != '0)
                begin
                    state_next = S_DONE;
                end
                else if (pr_es == '0)
                begin
                    state_next = S_FIN_SCAN;
                end
                else
                begin
                    state_next = S_FIN_MOD;
                end
            end
            S_FIN_MOD:
            begin
                if (mod_done)
                begin
                    state_next = (mod_rem != '0) ? S_DONE : S_FIN_SCAN;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        act_next       = act_reg;
        id_next        = id_reg;
        esize_next     = esize_reg;
        bytes_next     = bytes_reg;
        resv_next      = resv_reg;
        off_next       = off_reg;
        cursor_next    = cursor_reg;
        fcount_next    = fcount_reg;
        finalized_next = finalized_reg;
        alloc_next     = alloc_reg;
        live_next      = live_reg;
        idx_next       = idx_reg;
        pend_next      = 1'b0;
        pidx_next      = pidx_reg;
        bfound_next    = bfound_reg;
        bidx_next      = bidx_reg;
        bsize_next     = bsize_reg;
        boff_next      = boff_reg;
        pos_next       = pos_reg;
        stop_next      = stop_reg;
        poff_next      = poff_reg;
        psize_next     = psize_reg;
        noff_next      = noff_reg;
        nsize_next     = nsize_reg;
        fin_next       = fin_reg;
        rst_st_next    = rst_st_reg;
        res_off_next   = res_off_reg;
        res_resv_next  = res_resv_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_st_next    = rsp_st_reg;
        rsp_off_next   = rsp_off_reg;
        rsp_resv_next  = rsp_resv_reg;
        rsp_pool_next  = rsp_pool_reg;
        fr_en     = 1'b0;
        fr_addr   = idx_reg[FSW-1:0];
        fw_en     = 1'b0;
        fw_addr   = pidx_reg;
        fw_data   = fr_data;
        pr_en     = 1'b0;
        pr_addr   = id_reg;
        pw_en     = 1'b0;
        pw_data   = {base, resv_reg, esize_reg};
        mod_start = 1'b0;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    act_next   = action;
                    id_next    = id_fold(value_id);
                    esize_next = element_size;
                    bytes_next = PRW'(element_count) * PRW'(element_size);
                end
            end
            S_DISPATCH:
            begin
                rst_st_next   = ST_OK;
                res_off_next  = '0;
                res_resv_next = '0;
                idx_next      = '0;
                if (act_reg == ACT_NONE)
                begin
                    rst_st_next = ST_OK;
                end
                else if (finalized_reg)
                begin
                    rst_st_next = ST_FINALIZED;
                end
                else if (act_reg == ACT_ALLOC)
                begin
                    bfound_next = 1'b0;
                    resv_next   = AW'((bytes_e + ALIGN_M1_E) & ~ALIGN_M1_E);
                    if (alloc_reg[id_reg])
                    begin
                        rst_st_next = ST_DOUBLE;
                    end
                    else if (bytes_ovf)
                    begin
                        rst_st_next = ST_OVERFLOW;
                    end
                end
                else if (act_reg == ACT_FREE)
                begin
                    if (!live_reg[id_reg])
                    begin
                        rst_st_next = ST_NOT_LIVE;
                    end
                    else
                    begin
                        pr_en   = 1'b1;
                        pr_addr = id_reg;
                    end
                end
                else
                begin
                    finalized_next = 1'b1;
                    fin_next       = '0;
                end
            end
            S_ASCAN:
            begin
                if (scan_rd)
                begin
                    fr_en     = 1'b1;
                    idx_next  = idx_reg + FCW'(1);
                    pend_next = 1'b1;
                    pidx_next = idx_reg[FSW-1:0];
                end
                if (pend_reg && fr_size >= resv_reg && (!bfound_reg || fr_size < bsize_reg))
                begin
                    bfound_next = 1'b1;
                    bidx_next   = pidx_reg;
                    bsize_next  = fr_size;
                    boff_next   = fr_off;
                end
            end
            S_APLACE:
            begin
                if (place_ovf)
                begin
                    rst_st_next = ST_OVERFLOW;
                end
                else
                begin
                    pw_en                = 1'b1;
                    alloc_next[id_reg]   = 1'b1;
                    live_next[id_reg]    = 1'b1;
                    res_off_next         = base;
                    res_resv_next        = resv_reg;
                    if ((base + resv_reg) > cursor_reg)
                    begin
                        cursor_next = base + resv_reg;
                    end
                    if (bfound_reg)
                    begin
                        if (new_size != '0)
                        begin
                            fw_en   = 1'b1;
                            fw_addr = bidx_reg;
                            fw_data = {base + resv_reg, new_size};
                        end
                        else
                        begin
                            // The emptied range is squeezed out of the table.
                            idx_next = FCW'(bidx_reg) + FCW'(1);
                        end
                    end
                end
            end
            S_FREE_CHK:
            begin
                off_next  = pr_off;
                resv_next = pr_resv;
                idx_next  = '0;
                pos_next  = '0;
                stop_next = 1'b0;
                if (pr_resv == '0)
                begin
                    live_next[id_reg] = 1'b0;
                end
            end
            S_FSCAN:
            begin
                if (scan_rd)
                begin
                    fr_en     = 1'b1;
                    idx_next  = idx_reg + FCW'(1);
                    pend_next = 1'b1;
                    pidx_next = idx_reg[FSW-1:0];
                end
                if (pend_reg && !stop_reg)
                begin
                    if (fr_off <= off_reg)
                    begin
                        pos_next   = FCW'(pidx_reg) + FCW'(1);
                        poff_next  = fr_off;
                        psize_next = fr_size;
                    end
                    else
                    begin
                        stop_next  = 1'b1;
                        noff_next  = fr_off;
                        nsize_next = fr_size;
                    end
                end
            end
            S_FMERGE:
            begin
                if (tab_full)
                begin
                    rst_st_next = ST_FULL;
                end
                else
                begin
                    live_next[id_reg] = 1'b0;
                    if (mp)
                    begin
                        fw_en   = 1'b1;
                        fw_addr = FSW'(pos_reg - FCW'(1));
                        fw_data = {poff_reg, psize_reg + resv_reg + (mn ? nsize_reg : '0)};
                        idx_next = pos_reg + FCW'(1);
                    end
                    else if (mn)
                    begin
                        fw_en   = 1'b1;
                        fw_addr = pos_reg[FSW-1:0];
                        fw_data = {off_reg, nsize_reg + resv_reg};
                    end
                    else
                    begin
                        idx_next = fcount_reg;
                    end
                end
            end
            S_SHIFT_DN:
            begin
                if (scan_rd)
                begin
                    fr_en     = 1'b1;
                    idx_next  = idx_reg + FCW'(1);
                    pend_next = 1'b1;
                    pidx_next = idx_reg[FSW-1:0];
                end
                if (pend_reg)
                begin
                    fw_en   = 1'b1;
                    fw_addr = pidx_reg - FSW'(1);
                    fw_data = fr_data;
                end
                if (scan_end)
                begin
                    fcount_next = fcount_reg - FCW'(1);
                end
            end
            S_SHIFT_UP:
            begin
                if (idx_reg != pos_reg)
                begin
                    fr_en     = 1'b1;
                    fr_addr   = FSW'(idx_reg - FCW'(1));
                    idx_next  = idx_reg - FCW'(1);
                    pend_next = 1'b1;
                    pidx_next = FSW'(idx_reg - FCW'(1));
                end
                if (pend_reg)
                begin
                    fw_en   = 1'b1;
                    fw_addr = pidx_reg + FSW'(1);
                    fw_data = fr_data;
                end
                else if (idx_reg == pos_reg)
                begin
                    fw_en       = 1'b1;
                    fw_addr     = pos_reg[FSW-1:0];
                    fw_data     = {off_reg, resv_reg};
                    fcount_next = fcount_reg + FCW'(1);
                end
            end
            S_FIN_SCAN:
            begin
                if (fin_reg != VCW'(VALUE_COUNT))
                begin
                    if (alloc_reg[fin_id])
                    begin
                        pr_en   = 1'b1;
                        pr_addr = fin_id;
                    end
                    else
                    begin
                        fin_next = fin_reg + VCW'(1);
                    end
                end
            end
            S_FIN_CHK:
            begin
                if (pr_off[VEC_ALIGN_BITS-1:0] != '0)
                begin
                    rst_st_next = ST_VEC_MIS;
                end
                else if (pr_es == '0)
                begin
                    fin_next = fin_reg + VCW'(1);
                end
                else
                begin
                    mod_start = 1'b1;
                end
            end
            S_FIN_MOD:
            begin
                if (mod_done)
                begin
                    if (mod_rem != '0)
                    begin
                        rst_st_next = ST_ELEM_MIS;
                    end
                    else
                    begin
                        fin_next = fin_reg + VCW'(1);
                    end
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_st_next    = rst_st_reg;
                    rsp_off_next   = OUT_W'(64'(res_off_reg));
                    rsp_resv_next  = OUT_W'(64'(res_resv_reg));
                    rsp_pool_next  = OUT_W'(64'(cursor_reg));
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (fr_en)
        begin
            fr_data <= ftab[fr_addr];
        end
        if (fw_en)
        begin
            ftab[fw_addr] <= fw_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pr_en)
        begin
            pr_data <= pmem[pr_addr];
        end
        if (pw_en)
        begin
            pmem[id_reg] <= pw_data;
        end
    end

    bfsa_modu #(
        .DW (AW)
    ) u_modu (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (pr_off),
        .divisor  (pr_es),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cursor_reg    <= '0;
            fcount_reg    <= '0;
            finalized_reg <= 1'b0;
            alloc_reg     <= '0;
            live_reg      <= '0;
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cursor_reg    <= cursor_next;
            fcount_reg    <= fcount_next;
            finalized_reg <= finalized_next;
            alloc_reg     <= alloc_next;
            live_reg      <= live_next;
            pend_reg      <= pend_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg      <= act_next;
        id_reg       <= id_next;
        esize_reg    <= esize_next;
        bytes_reg    <= bytes_next;
        resv_reg     <= resv_next;
        off_reg      <= off_next;
        idx_reg      <= idx_next;
        pidx_reg     <= pidx_next;
        bfound_reg   <= bfound_next;
        bidx_reg     <= bidx_next;
        bsize_reg    <= bsize_next;
        boff_reg     <= boff_next;
        pos_reg      <= pos_next;
        stop_reg     <= stop_next;
        poff_reg     <= poff_next;
        psize_reg    <= psize_next;
        noff_reg     <= noff_next;
        nsize_reg    <= nsize_next;
        fin_reg      <= fin_next;
        rst_st_reg   <= rst_st_next;
        res_off_reg  <= res_off_next;
        res_resv_reg <= res_resv_next;
        rsp_st_reg   <= rsp_st_next;
        rsp_off_reg  <= rsp_off_next;
        rsp_resv_reg <= rsp_resv_next;
        rsp_pool_reg <= rsp_pool_next;
    end

    assign rsp_valid      = rsp_valid_reg;
    assign status         = rsp_st_reg;
    assign offset         = rsp_off_reg;
    assign reserved_bytes = rsp_resv_reg;
    assign pool_bytes     = rsp_pool_reg;

    a_fcount_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fcount_reg <= FCW'(FREE_SLOTS))
        else $error("free table count beyond its slots");

    a_live_alloc: assert property (@(posedge clk) disable iff (!rst_n)
        (live_reg & ~alloc_reg) == '0)
        else $error("live value that was never allocated");

    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (fr_en && fw_en) |-> (fr_addr != fw_addr))
        else $error("free table read and write hit the same entry");

    a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> (state_reg == S_DISPATCH))
        else $error("accepted word not dispatched");

endmodule

FILE: design/bfsa_modu.sv
// Iterative remainder of an address by a small element size, four bits per cycle.
module bfsa_modu
    import bfsa_pkg::*;
#(
    parameter int DW = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DW-1:0]     dividend,
    input  logic [ELEM_W-1:0] divisor,
    output logic              done,
    output logic [ELEM_W-1:0] rem
);

    localparam int NST  = (DW + 3) / 4;
    localparam int PADW = NST * 4;
    localparam int CW   = $clog2(NST + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [PADW-1:0]   sh_reg, sh_next;
    logic [ELEM_W-1:0] rem_reg, rem_next;
    logic [ELEM_W-1:0] div_reg, div_next;
    logic [ELEM_W-1:0] step_rem;

    // Four restoring steps on the running remainder.
    always_comb
    begin
        logic [ELEM_W:0] t;
        logic [ELEM_W-1:0] r;
        r = rem_reg;
        for (int k = 0; k < 4; k++)
        begin
            t = {r, sh_reg[PADW-1-k]};
            if (t >= {1'b0, div_reg})
            begin
                t = t - {1'b0, div_reg};
            end
            r = t[ELEM_W-1:0];
        end
        step_rem = r;
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        sh_next   = sh_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(NST);
            sh_next   = PADW'(dividend);
            rem_next  = '0;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            sh_next  = sh_reg << 4;
            rem_next = step_rem;
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg  <= sh_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule
